// ----- hdl/ldc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package ldc_pkg;

    // Field widths
    localparam int ANGLE_W     = 14;
    localparam int BAND_W      = 14;
    localparam int STEEP_W     = 13;
    localparam int COUNT_W     = 3;
    localparam int SCORE_W     = 4;
    localparam int STATUS_W    = 2;
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 14;

    // Angle scaling
    localparam int DEF_ANGLE_FRAC_BITS = 6;
    localparam int RIGHT_ANGLE_DEG     = 90;

    // Register reset values
    localparam logic               RST_COUNTED_MODE   = 1'b1;
    localparam logic [BAND_W-1:0]  RST_BALANCE_BAND   = BAND_W'(1280);
    localparam logic [BAND_W-1:0]  RST_MATCH_BAND     = BAND_W'(64);
    localparam logic [STEEP_W-1:0] RST_STEEP_LIMIT    = STEEP_W'(2560);
    localparam logic [BAND_W-1:0]  RST_REVERSE_MARGIN = BAND_W'(128);
    localparam logic [COUNT_W-1:0] RST_COUNT_LIMIT    = COUNT_W'(2);
    localparam logic [COUNT_W-1:0] RST_SWITCH_LEVEL   = COUNT_W'(1);

    // Register indexes on the configuration port
    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_COUNTED_MODE   = 3'd0,
        CFG_BALANCE_BAND   = 3'd1,
        CFG_MATCH_BAND     = 3'd2,
        CFG_STEEP_LIMIT    = 3'd3,
        CFG_REVERSE_MARGIN = 3'd4,
        CFG_COUNT_LIMIT    = 3'd5,
        CFG_SWITCH_LEVEL   = 3'd6
    } cfg_idx_t;

    // Lane status
    typedef enum logic [STATUS_W-1:0] {
        ST_NORMAL = 2'd0,
        ST_LEFT   = 2'd1,
        ST_RIGHT  = 2'd2
    } status_t;

    // Vote cast for one word
    typedef enum logic [1:0] {
        VOTE_NORMAL = 2'd0,
        VOTE_LEFT   = 2'd1,
        VOTE_RIGHT  = 2'd2,
        VOTE_NONE   = 2'd3
    } vote_t;

    typedef struct packed {
        logic               counted_mode;
        logic [BAND_W-1:0]  balance_band;
        logic [BAND_W-1:0]  match_band;
        logic [STEEP_W-1:0] steep_limit;
        logic [BAND_W-1:0]  reverse_margin;
        logic [COUNT_W-1:0] count_limit;
        logic [COUNT_W-1:0] switch_level;
    } cfg_t;

    typedef struct packed {
        logic               left_valid;
        logic [ANGLE_W-1:0] left_angle;
        logic               right_valid;
        logic [ANGLE_W-1:0] right_angle;
        logic [ANGLE_W-1:0] left_track_angle;
        logic [ANGLE_W-1:0] right_track_angle;
    } item_t;

endpackage

`default_nettype wire

// ----- hdl/ldc_cfg.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ldc_cfg
    import ldc_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_valid,
    output logic                        cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    output cfg_t                        cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    // Always take a write
    assign cfg_ready = 1'b1;
    assign cfg      = cfg_reg;

    // Decode the register index; unknown indexes drop the word
    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_COUNTED_MODE:   cfg_next.counted_mode   = cfg_data[0];
                CFG_BALANCE_BAND:   cfg_next.balance_band   = cfg_data[BAND_W-1:0];
                CFG_MATCH_BAND:     cfg_next.match_band     = cfg_data[BAND_W-1:0];
                CFG_STEEP_LIMIT:    cfg_next.steep_limit    = cfg_data[STEEP_W-1:0];
                CFG_REVERSE_MARGIN: cfg_next.reverse_margin = cfg_data[BAND_W-1:0];
                CFG_COUNT_LIMIT:    cfg_next.count_limit    = cfg_data[COUNT_W-1:0];
                CFG_SWITCH_LEVEL:   cfg_next.switch_level   = cfg_data[COUNT_W-1:0];
                default:            cfg_next = cfg_reg;
            endcase
        end
    end

    // Hold the register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.counted_mode   <= RST_COUNTED_MODE;
            cfg_reg.balance_band   <= RST_BALANCE_BAND;
            cfg_reg.match_band     <= RST_MATCH_BAND;
            cfg_reg.steep_limit    <= RST_STEEP_LIMIT;
            cfg_reg.reverse_margin <= RST_REVERSE_MARGIN;
            cfg_reg.count_limit    <= RST_COUNT_LIMIT;
            cfg_reg.switch_level   <= RST_SWITCH_LEVEL;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/ldc_vote.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ldc_vote
    import ldc_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
)
(
    input  wire item_t   item,
    input  wire cfg_t    cfg,
    input  wire status_t status,
    output vote_t        vote
);

    localparam int REF_VAL  = RIGHT_ANGLE_DEG << ANGLE_FRAC_BITS;
    localparam int REF_BITS = ($clog2(REF_VAL + 1) > ANGLE_W) ? $clog2(REF_VAL + 1) : ANGLE_W;
    // Room for a tilt plus a margin, with sign
    localparam int TILT_W   = REF_BITS + 3;

    localparam logic signed [TILT_W-1:0] REF_TILT = TILT_W'(REF_VAL);

    typedef logic signed [TILT_W-1:0] tilt_t;

    function automatic tilt_t absd(input tilt_t a, input tilt_t b);
        return (a > b) ? (a - b) : (b - a);
    endfunction

    tilt_t ll, rr, lt, rt;
    tilt_t balance_s, match_s, steep_s, margin_s;
    logic  bal, l_match, r_match;
    logic  l_up, l_dn, r_up, r_dn, l_steep, r_steep;
    logic  l_far_up, l_far_dn, r_far_up, r_far_dn;
    logic  lv, rv;

    // Form tilts: 90 minus left angle, right angle minus 90
    assign ll = REF_TILT - tilt_t'({{(TILT_W-ANGLE_W){1'b0}}, item.left_angle});
    assign rr = tilt_t'({{(TILT_W-ANGLE_W){1'b0}}, item.right_angle}) - REF_TILT;
    assign lt = REF_TILT - tilt_t'({{(TILT_W-ANGLE_W){1'b0}}, item.left_track_angle});
    assign rt = tilt_t'({{(TILT_W-ANGLE_W){1'b0}}, item.right_track_angle}) - REF_TILT;

    assign balance_s = tilt_t'({{(TILT_W-BAND_W){1'b0}}, cfg.balance_band});
    assign match_s   = tilt_t'({{(TILT_W-BAND_W){1'b0}}, cfg.match_band});
    assign steep_s   = tilt_t'({{(TILT_W-STEEP_W){1'b0}}, cfg.steep_limit});
    assign margin_s  = tilt_t'({{(TILT_W-BAND_W){1'b0}}, cfg.reverse_margin});

    assign lv = item.left_valid;
    assign rv = item.right_valid;

    // Compare against bands
    assign bal      = absd(ll, rr) <= balance_s;
    assign l_match  = absd(ll, lt) < match_s;
    assign r_match  = absd(rr, rt) < match_s;
    assign l_up     = ll > lt;
    assign l_dn     = ll < lt;
    assign r_up     = rr > rt;
    assign r_dn     = rr < rt;
    assign l_steep  = ll > steep_s;
    assign r_steep  = rr > steep_s;
    assign l_far_up = ll > (lt + margin_s);
    assign l_far_dn = ll < (lt - margin_s);
    assign r_far_up = rr > (rt + margin_s);
    assign r_far_dn = rr < (rt - margin_s);

    // Cast the vote from the current status
    always_comb
    begin
        vote = VOTE_NONE;
        unique case (status)
            ST_NORMAL:
            begin
                if (lv && rv)
                begin
                    if (bal || (l_match && r_match))
                        vote = VOTE_NORMAL;
                    else if ((ll > rr) && l_up && l_steep)
                        vote = VOTE_LEFT;
                    else if ((ll < rr) && r_up && r_steep)
                        vote = VOTE_RIGHT;
                end
                else if (rv)
                begin
                    if (r_up && r_steep)
                        vote = VOTE_RIGHT;
                end
                else if (lv)
                begin
                    if (l_up && l_steep)
                        vote = VOTE_LEFT;
                end
                else
                begin
                    vote = VOTE_NORMAL;
                end
            end
            ST_LEFT:
            begin
                if (lv && rv)
                begin
                    if (l_up && r_dn)
                        vote = VOTE_LEFT;
                    else if (l_match && r_match)
                        vote = VOTE_NORMAL;
                    else if (l_dn && r_up)
                        vote = VOTE_RIGHT;
                end
                else if (rv)
                begin
                    if (r_dn)
                        vote = VOTE_LEFT;
                    else if (r_match)
                        vote = VOTE_NORMAL;
                    else if (r_far_up)
                        vote = VOTE_RIGHT;
                end
                else if (lv)
                begin
                    if (l_up)
                        vote = VOTE_LEFT;
                    else if (l_match)
                        vote = VOTE_NORMAL;
                    else if (l_far_dn)
                        vote = VOTE_RIGHT;
                end
            end
            ST_RIGHT:
            begin
                if (lv && rv)
                begin
                    if (l_dn && r_up)
                        vote = VOTE_RIGHT;
                    else if (l_match && r_match)
                        vote = VOTE_NORMAL;
                    else if (l_up && r_dn)
                        vote = VOTE_LEFT;
                end
                else if (rv)
                begin
                    if (r_up)
                        vote = VOTE_RIGHT;
                    else if (r_match)
                        vote = VOTE_NORMAL;
                    else if (r_far_dn)
                        vote = VOTE_LEFT;
                end
                else if (lv)
                begin
                    if (l_dn)
                        vote = VOTE_RIGHT;
                    else if (l_match)
                        vote = VOTE_NORMAL;
                    else if (l_far_up)
                        vote = VOTE_LEFT;
                end
            end
            default: vote = VOTE_NONE;
        endcase
    end

endmodule

`default_nettype wire

// ----- hdl/ldc_score.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ldc_score
    import ldc_pkg::*;
(
    input  wire vote_t                    vote,
    input  wire cfg_t                     cfg,
    input  wire status_t                  status,
    input  wire logic signed [SCORE_W-1:0] score,
    output status_t                       status_out,
    output logic signed [SCORE_W-1:0]     score_out
);

    typedef logic signed [SCORE_W:0] wide_t;

    wide_t s_step;
    wide_t s_sat;
    wide_t lim;
    wide_t lvl;

    assign lim = wide_t'({2'b00, cfg.count_limit});
    assign lvl = wide_t'({2'b00, cfg.switch_level});

    // Move the score by one vote
    always_comb
    begin
        s_step = {score[SCORE_W-1], score};
        case (vote)
            VOTE_LEFT:  s_step = s_step - wide_t'(1);
            VOTE_RIGHT: s_step = s_step + wide_t'(1);
            VOTE_NORMAL:
            begin
                if (status == ST_LEFT)
                    s_step = s_step + wide_t'(1);
                else if (status == ST_RIGHT)
                    s_step = s_step - wide_t'(1);
                else if (s_step > wide_t'(0))
                    s_step = s_step - wide_t'(1);
                else if (s_step < wide_t'(0))
                    s_step = s_step + wide_t'(1);
            end
            default: s_step = {score[SCORE_W-1], score};
        endcase
    end

    // Saturate at the count limit
    always_comb
    begin
        if (s_step > lim)
            s_sat = lim;
        else if (s_step < -lim)
            s_sat = -lim;
        else
            s_sat = s_step;
    end

    // Pick the new status and score
    always_comb
    begin
        if (cfg.counted_mode)
        begin
            score_out = s_sat[SCORE_W-1:0];
            if (s_sat > lvl)
                status_out = ST_RIGHT;
            else if (s_sat < -lvl)
                status_out = ST_LEFT;
            else
                status_out = ST_NORMAL;
        end
        else
        begin
            score_out = score;
            case (vote)
                VOTE_NORMAL: status_out = ST_NORMAL;
                VOTE_LEFT:   status_out = ST_LEFT;
                VOTE_RIGHT:  status_out = ST_RIGHT;
                default:     status_out = status;
            endcase
        end
    end

endmodule

`default_nettype wire

// ----- hdl/lane_departure_classifier.sv -----
// Flow: an accepted word waits in the input register, then its result is registered.
// Throughput: one word per cycle unless the result stalls; the input register
// and the status/score register form a two-stage pipe, and the vote of each
// word reads the status left by the word before it, which that register holds.
// Reset: rst_n clears status to normal, score to zero, all valid flags,
// and loads the configuration registers with their defaults.
`timescale 1ns / 1ps
`default_nettype none

module lane_departure_classifier
    import ldc_pkg::*;
#(
    parameter int ANGLE_FRAC_BITS = DEF_ANGLE_FRAC_BITS
)
(
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_valid,
    output logic                           cfg_ready,
    input  wire logic [CFG_INDEX_W-1:0]    cfg_index,
    input  wire logic [CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                      in_valid,
    output logic                           in_ready,
    input  wire logic                      left_valid,
    input  wire logic [ANGLE_W-1:0]        left_angle,
    input  wire logic                      right_valid,
    input  wire logic [ANGLE_W-1:0]        right_angle,
    input  wire logic [ANGLE_W-1:0]        left_track_angle,
    input  wire logic [ANGLE_W-1:0]        right_track_angle,
    output logic                           out_valid,
    input  wire logic                      out_ready,
    output logic [STATUS_W-1:0]            lane_status,
    output logic signed [SCORE_W-1:0]      vote_score
);

    cfg_t                      cfg;
    item_t                     item_reg;
    logic                      item_valid_reg;
    logic                      out_valid_reg;
    logic                      out_valid_next;
    status_t                   status_reg;
    status_t                   status_next;
    logic signed [SCORE_W-1:0] score_reg;
    logic signed [SCORE_W-1:0] score_next;
    vote_t                     vote;
    logic                      advance;
    logic                      in_take;

    ldc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ldc_vote #(
        .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
    ) u_vote (
        .item   (item_reg),
        .cfg    (cfg),
        .status (status_reg),
        .vote   (vote)
    );

    ldc_score u_score (
        .vote       (vote),
        .cfg        (cfg),
        .status     (status_reg),
        .score      (score_reg),
        .status_out (status_next),
        .score_out  (score_next)
    );

    // Advance the held word when the result slot is free or being taken
    assign advance  = item_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !item_valid_reg || advance;
    assign in_take  = in_valid && in_ready;

    always_comb
    begin
        if (advance)
            out_valid_next = 1'b1;
        else if (out_ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    // Hold control and state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            status_reg     <= ST_NORMAL;
            score_reg      <= '0;
        end
        else
        begin
            if (in_take)
                item_valid_reg <= 1'b1;
            else if (advance)
                item_valid_reg <= 1'b0;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                status_reg <= status_next;
                score_reg  <= score_next;
            end
        end
    end

    // Capture the input word
    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            item_reg.left_valid        <= left_valid;
            item_reg.left_angle        <= left_angle;
            item_reg.right_valid       <= right_valid;
            item_reg.right_angle       <= right_angle;
            item_reg.left_track_angle  <= left_track_angle;
            item_reg.right_track_angle <= right_track_angle;
        end
    end

    // The status and score registers are the result word
    assign out_valid   = out_valid_reg;
    assign lane_status = status_reg;
    assign vote_score  = score_reg;

endmodule

`default_nettype wire

// ----- hdl/ldc_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module ldc_checker
    import ldc_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      in_valid,
    input wire logic                      in_ready,
    input wire logic                      out_valid,
    input wire logic                      out_ready,
    input wire logic [STATUS_W-1:0]       lane_status,
    input wire logic signed [SCORE_W-1:0] vote_score
);

    // Status code is one of the three defined codes
    a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (lane_status == ST_NORMAL || lane_status == ST_LEFT ||
                       lane_status == ST_RIGHT))
        else $error("lane_status carries an undefined code");

    // Score never reaches the most negative code
    a_score_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (vote_score != {1'b1, {(SCORE_W-1){1'b0}}}))
        else $error("vote_score out of range");

    // Input stalls only behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (out_valid && !out_ready))
        else $error("input stalled while the result slot was free");

    // An accepted word is followed by a valid result
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |-> ##2 out_valid)
        else $error("no result after an accepted word");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=>
            (out_valid && $stable(lane_status) && $stable(vote_score)))
        else $error("result changed while stalled");

endmodule

bind lane_departure_classifier ldc_checker u_ldc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .lane_status (lane_status),
    .vote_score  (vote_score)
);

`default_nettype wire
